// ===== design/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants for the floppy drive controller.
// ----------------------------------------------------------------------------
package fdc_pkg;

    // operations
    localparam logic [2:0] OP_POLL    = 3'd0;
    localparam logic [2:0] OP_SET_IRQ = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BUSY     = 3'd1;
    localparam logic [2:0] ERR_NO_MEDIA = 3'd2;
    localparam logic [2:0] ERR_PROTECT  = 3'd3;
    localparam logic [2:0] ERR_EJECT    = 3'd4;
    localparam logic [2:0] ERR_BAD_SECT = 3'd5;

    // drive states reported by poll
    localparam logic [1:0] DRV_NO_MEDIA = 2'd0;
    localparam logic [1:0] DRV_READY    = 2'd1;
    localparam logic [1:0] DRV_BUSY     = 2'd3;

    // busy kinds
    localparam logic [1:0] BUSY_IDLE  = 2'd0;
    localparam logic [1:0] BUSY_READ  = 2'd1;
    localparam logic [1:0] BUSY_WRITE = 2'd2;

    // DMA transfer kinds
    localparam logic [1:0] XFER_NONE       = 2'd0;
    localparam logic [1:0] XFER_DISK_TO_MEM = 2'd1;
    localparam logic [1:0] XFER_MEM_TO_BUF = 2'd2;
    localparam logic [1:0] XFER_BUF_TO_DISK = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SEEK_STEP = 2'd0;
    localparam logic [1:0] CFG_SECTOR    = 2'd1;
    localparam logic [1:0] CFG_IDLE      = 2'd2;

    localparam logic [15:0] SEEK_STEP_RESET = 16'd2400;
    localparam logic [15:0] SECTOR_RESET    = 16'd33;
    localparam logic [15:0] IDLE_RESET      = 16'd50000;

    localparam logic [15:0] SECTOR_COUNT      = 16'd1440;
    localparam logic [4:0]  SECTORS_PER_TRACK = 5'd18;
    localparam logic [8:0]  HOME_TRACK        = 9'd400;
    // floor(x * 3641 / 2^16) == x / 18 for x below 1440
    localparam logic [11:0] TRACK_RECIP       = 12'd3641;

    typedef struct packed {
        logic [2:0]  operation;
        logic        media_present;
        logic [15:0] sector_number;
        logic [15:0] memory_address;
        logic [15:0] interrupt_word;
    } item_t;

    typedef struct packed {
        logic [1:0]  drive_state;
        logic [2:0]  error_code;
        logic        accepted;
        logic        irq_fire;
        logic [15:0] irq_message;
        logic [1:0]  transfer_kind;
        logic [10:0] transfer_sector;
        logic [15:0] transfer_address;
    } result_t;

    typedef struct packed {
        logic [15:0] seek_step_ticks;
        logic [15:0] sector_ticks;
        logic [15:0] idle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [8:0]  head_track;
        logic [4:0]  rotation_sector;
        logic [10:0] target_sector;
        logic [6:0]  target_track;
        logic [4:0]  target_phase;     // (target_sector + 1) mod 18
        logic [15:0] host_address;
        logic [15:0] irq_word;
        logic [1:0]  busy_kind;
        logic [2:0]  last_error;
        logic [15:0] countdown;
    } fdc_state_t;

endpackage

// ===== design/fdc_step.sv =====
// ----------------------------------------------------------------------------
// fdc_step
// Next-state and result logic for one command or tick.
// ----------------------------------------------------------------------------
module fdc_step (
    input  fdc_pkg::item_t      item,
    input  fdc_pkg::cfg_t       cfg,
    input  fdc_pkg::fdc_state_t st,
    output fdc_pkg::fdc_state_t st_next,
    output fdc_pkg::result_t    res
);
    import fdc_pkg::*;

    function automatic logic [4:0] rot_inc(input logic [4:0] r);
        rot_inc = (r == SECTORS_PER_TRACK - 5'd1) ? 5'd0 : r + 5'd1;
    endfunction

    // 1535 mod 18 = 5
    function automatic logic [4:0] rot_add5(input logic [4:0] r);
        rot_add5 = (r >= SECTORS_PER_TRACK - 5'd5) ? r - (SECTORS_PER_TRACK - 5'd5)
                                                   : r + 5'd5;
    endfunction

    logic [22:0] track_prod;
    logic [6:0]  req_track;
    logic [10:0] req_rem;
    logic [4:0]  req_phase;
    logic [2:0]  req_err;
    logic        req_ok;
    logic [15:0] cnt_dec;
    logic [4:0]  rot_step;
    logic        raise;

    always_comb begin
        track_prod = item.sector_number[10:0] * TRACK_RECIP;
        req_track  = track_prod[22:16];
        req_rem    = item.sector_number[10:0] - {req_track, 4'b0000}
                   - {3'b000, req_track, 1'b0};
        req_phase  = rot_inc(req_rem[4:0]);
        cnt_dec    = (st.countdown != 16'd0) ? st.countdown - 16'd1 : 16'd0;
        rot_step   = rot_inc(st.rotation_sector);

        req_ok  = 1'b0;
        req_err = st.last_error;
        if (st.busy_kind != BUSY_IDLE) begin
            req_err = ERR_BUSY;
        end else if (!item.media_present) begin
            req_err = ERR_NO_MEDIA;
        end else if (item.sector_number >= SECTOR_COUNT) begin
            req_err = ERR_BAD_SECT;
        end else begin
            req_ok = 1'b1;
        end

        st_next = st;
        res     = '0;
        raise   = 1'b0;

        case (item.operation) inside
            OP_POLL: begin
                if (!item.media_present) begin
                    res.drive_state = DRV_NO_MEDIA;
                end else if (st.busy_kind != BUSY_IDLE) begin
                    res.drive_state = DRV_BUSY;
                end else begin
                    res.drive_state = DRV_READY;
                end
                res.error_code     = st.last_error;
                raise              = (st.last_error != ERR_NONE);
                st_next.last_error = ERR_NONE;
            end
            OP_SET_IRQ: begin
                st_next.irq_word = item.interrupt_word;
            end
            OP_READ, OP_WRITE: begin
                st_next.last_error = req_err;
                res.error_code     = req_err;
                raise              = req_ok || (req_err != st.last_error);
                if (req_ok) begin
                    res.accepted          = 1'b1;
                    st_next.target_sector = item.sector_number[10:0];
                    st_next.target_track  = req_track;
                    st_next.target_phase  = req_phase;
                    st_next.host_address  = item.memory_address;
                    if (item.operation == OP_WRITE) begin
                        st_next.busy_kind    = BUSY_WRITE;
                        res.transfer_kind    = XFER_MEM_TO_BUF;
                        res.transfer_sector  = item.sector_number[10:0];
                        res.transfer_address = item.memory_address;
                    end else begin
                        st_next.busy_kind = BUSY_READ;
                    end
                end
            end
            OP_TICK: begin
                st_next.countdown = cnt_dec;
                if (cnt_dec == 16'd0) begin
                    if (st.busy_kind == BUSY_IDLE) begin
                        st_next.rotation_sector = rot_add5(st.rotation_sector);
                        st_next.countdown       = cfg.idle_ticks;
                    end else if (!item.media_present) begin
                        // media pulled mid-operation; countdown stays at zero
                        st_next.last_error = ERR_EJECT;
                        st_next.busy_kind  = BUSY_IDLE;
                        raise              = 1'b1;
                    end else if ({2'b00, st.target_track} != st.head_track) begin
                        // 73 mod 18 = 1, same rotation advance as a sector step
                        st_next.head_track = ({2'b00, st.target_track} < st.head_track)
                                           ? st.head_track - 9'd1 : st.head_track + 9'd1;
                        st_next.rotation_sector = rot_step;
                        st_next.countdown       = cfg.seek_step_ticks;
                    end else begin
                        st_next.rotation_sector = rot_step;
                        st_next.countdown       = cfg.sector_ticks;
                        if (st.target_phase == rot_step) begin
                            res.transfer_kind    = (st.busy_kind == BUSY_READ)
                                                 ? XFER_DISK_TO_MEM : XFER_BUF_TO_DISK;
                            res.transfer_sector  = st.target_sector;
                            res.transfer_address = st.host_address;
                            st_next.busy_kind    = BUSY_IDLE;
                            raise                = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        res.irq_fire    = raise && (st.irq_word != 16'd0);
        res.irq_message = res.irq_fire ? st.irq_word : 16'd0;
    end

endmodule

// ===== design/floppy_drive_controller_top.sv =====
// ----------------------------------------------------------------------------
// floppy_drive_controller_top
// Floppy controller with seek and rotation model, stream in, stream out.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while m_tready is high; input register feeds
//   fdc_step, result register. Each item waits in the input register; its result
//   is on m_ from the result register until m_tready; backpressure stalls both registers.
// Reset: synchronous, active-low aresetn clears valids, drive state and the
//   timing registers (2400/33/50000); head parks at track 400.
module floppy_drive_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: media_present, sector_number, memory_address, interrupt_word
    input  logic [55:0] s_tdata,
    // tuser: operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: drive_state, error_code, accepted, irq_fire, irq_message,
    //        transfer_sector, transfer_address
    output logic [55:0] m_tdata,
    // tuser: transfer_kind
    output logic [1:0]  m_tuser
);
    import fdc_pkg::*;

    cfg_t       cfg_reg;
    fdc_state_t st_reg;
    fdc_state_t st_next;
    item_t      in_item_reg;
    logic       in_valid_reg;
    result_t    res_next;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seek_step_ticks <= SEEK_STEP_RESET;
            cfg_reg.sector_ticks    <= SECTOR_RESET;
            cfg_reg.idle_ticks      <= IDLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SEEK_STEP: cfg_reg.seek_step_ticks <= cfg_wdata;
                CFG_SECTOR:    cfg_reg.sector_ticks    <= cfg_wdata;
                CFG_IDLE:      cfg_reg.idle_ticks      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.operation      <= s_tuser;
            in_item_reg.media_present  <= s_tdata[0];
            in_item_reg.sector_number  <= s_tdata[16:1];
            in_item_reg.memory_address <= s_tdata[32:17];
            in_item_reg.interrupt_word <= s_tdata[48:33];
        end
    end

    fdc_step u_step (
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // host_address has no reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.head_track      <= HOME_TRACK;
            st_reg.rotation_sector <= 5'd0;
            st_reg.target_sector   <= 11'd0;
            st_reg.target_track    <= 7'd0;
            st_reg.target_phase    <= 5'd1;
            st_reg.irq_word        <= 16'd0;
            st_reg.busy_kind       <= BUSY_IDLE;
            st_reg.last_error      <= ERR_NONE;
            st_reg.countdown       <= 16'd0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.transfer_kind;
    assign m_tdata  = {6'b000000, out_reg.transfer_address, out_reg.transfer_sector,
                       out_reg.irq_message, out_reg.irq_fire, out_reg.accepted,
                       out_reg.error_code, out_reg.drive_state};

`ifndef SYNTHESIS
    a_rotation_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.rotation_sector < SECTORS_PER_TRACK)
        else $error("rotation sector out of range");

    a_head_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (st_reg.head_track == $past(st_reg.head_track))
                        || (st_reg.head_track == $past(st_reg.head_track) + 9'd1)
                        || (st_reg.head_track == $past(st_reg.head_track) - 9'd1))
        else $error("head moved more than one track");

    a_busy_target_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.busy_kind != BUSY_IDLE) |-> ({5'd0, st_reg.target_sector} < SECTOR_COUNT))
        else $error("busy with out-of-range target sector");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result produced without an input item");
`endif

endmodule
